@@ sv/cce_pkg.sv @@
// Package for the CSV column extractor.
// Holds the parser phase type and the character constants; no dependencies.
package cce_pkg;

    // Parser phase within the current field
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PLAIN  = 2'd1,
        PH_QUOTED = 2'd2,
        PH_QSEEN  = 2'd3
    } phase_t;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_OUT_W = 9;
    localparam int unsigned VALUE_W  = 16;

endpackage

@@ sv/cce_if.sv @@
// Valid/ready channel interfaces of the CSV column extractor.
// Character channel in, field result channel out; no dependencies.
interface cce_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       line_end;

    modport source (output valid, data_byte, line_end, input ready);
    modport sink   (input valid, data_byte, line_end, output ready);
endinterface

interface cce_field_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        field_done;
    logic        found;
    logic [8:0]  field_length;
    logic [15:0] lines_with_value;

    modport source (output valid, byte_valid, out_byte, field_done, found,
                    field_length, lines_with_value, input ready);
    modport sink   (input valid, byte_valid, out_byte, field_done, found,
                    field_length, lines_with_value, output ready);
endinterface

@@ sv/csv_column_extractor.sv @@
// CSV column extractor: splits a character stream into fields and emits one column.
// Depends on cce_pkg and the channel interfaces in cce_if.sv.
//
// Usage: characters of a CSV line arrive one word per cycle on the text channel;
// a word with line_end set closes the line. Fields split on ';' or '|', and a
// field opening with a double quote runs to a quote followed by a delimiter or
// the line end. Each character of the column chosen by target_column leaves as
// a byte word on the field channel; at the end of that field, or of a line
// without it, a done word carries found, field_length and lines_with_value.
// User writes target_column (cfg_wr_en/cfg_wr_data) only while idle; not checked.
//
// Throughput: one character per cycle. A result word is loaded into the output
// register when its character is accepted and appears on the field channel in
// the next cycle. Words that cause no result only update the parser state.
// Stall: while a result waits in the output register and the receiver holds
// ready low, text.ready drops; when the receiver takes the word, a new
// character is taken in the same cycle.
// Reset: parser at field start, column 0, counters cleared, target_column 0,
// output register empty.
module csv_column_extractor #(
    parameter int unsigned FIELD_LEN_MAX = 511,
    parameter int unsigned COLUMN_MAX    = 255
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [cce_pkg::BYTE_W-1:0] cfg_wr_data,
    cce_char_if.sink                text,
    cce_field_if.source             field
);
    import cce_pkg::*;

    localparam int unsigned LW = $clog2(FIELD_LEN_MAX + 1);
    localparam int unsigned CW = $clog2(COLUMN_MAX + 1);

    // Parser state
    phase_t              phase_reg, phase_next;
    logic                finished_reg, finished_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [BYTE_W-1:0]   target_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_byte_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_done_reg;
    logic                out_found_reg;
    logic [LEN_OUT_W-1:0] out_len_reg;
    logic [VALUE_W-1:0]  out_lines_reg;

    logic acc, sel, is_delim, is_quote, is_nul, active, content_end;
    logic field_end_char, field_end, done_present, done_absent, emit, has_result;
    logic [CW+BYTE_W-1:0]    col_ext, tgt_ext;
    logic [LW+LEN_OUT_W-1:0] len_ext;

    // Accept while the output register is free or being emptied
    assign text.ready = !out_valid_reg || field.ready;
    assign acc        = text.valid && text.ready;

    // Decode the character and the current field
    assign is_delim = (text.data_byte == CH_SEMI) || (text.data_byte == CH_PIPE);
    assign is_quote = (text.data_byte == CH_QUOTE);
    assign is_nul   = (text.data_byte == CH_NUL);
    assign col_ext  = {{BYTE_W{1'b0}}, col_reg};
    assign tgt_ext  = {{CW{1'b0}}, target_reg};
    assign sel      = (col_ext == tgt_ext);
    assign len_ext  = {{LEN_OUT_W{1'b0}}, len_reg};

    // Classify the events that this word causes
    assign active         = !text.line_end && !finished_reg && !is_nul;
    assign content_end    = !finished_reg && (text.line_end || is_nul);
    assign field_end_char = active && is_delim && (phase_reg != PH_QUOTED);
    assign field_end      = field_end_char || (content_end && (phase_reg != PH_START));
    assign done_present   = field_end && sel;
    assign done_absent    = content_end && !done_present;
    assign emit = active && sel && !field_end_char
               && !(is_quote && (phase_reg == PH_START || phase_reg == PH_QUOTED));
    assign has_result = emit || done_present || done_absent;

    // Next parser phase
    always_comb
    begin
        phase_next = phase_reg;
        if (text.line_end || content_end || field_end_char)
        begin
            phase_next = PH_START;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_START:  phase_next = is_quote ? PH_QUOTED : PH_PLAIN;
                PH_PLAIN:  phase_next = PH_PLAIN;
                PH_QUOTED: phase_next = is_quote ? PH_QSEEN : PH_QUOTED;
                PH_QSEEN:  phase_next = PH_QUOTED;
                default:   phase_next = PH_START;
            endcase
        end
    end

    // Next counters and line status
    always_comb
    begin
        col_next      = col_reg;
        len_next      = len_reg;
        val_next      = val_reg;
        finished_next = finished_reg;
        if (field_end && !sel && (col_reg < CW'(COLUMN_MAX)))
        begin
            col_next = col_reg + 1'b1;
        end
        if (emit && (len_reg < LW'(FIELD_LEN_MAX)))
        begin
            len_next = len_reg + 1'b1;
        end
        if (done_present && (len_reg != '0) && (val_reg != {VALUE_W{1'b1}}))
        begin
            val_next = val_reg + 1'b1;
        end
        if (done_present || done_absent)
        begin
            finished_next = 1'b1;
        end
        if (text.line_end)
        begin
            col_next      = '0;
            len_next      = '0;
            finished_next = 1'b0;
        end
    end

    // Hold the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            finished_reg <= 1'b0;
            col_reg      <= '0;
            len_reg      <= '0;
            val_reg      <= '0;
        end
        else if (acc)
        begin
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
            col_reg      <= col_next;
            len_reg      <= len_next;
            val_reg      <= val_next;
        end
    end

    // Hold the column register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_reg <= cfg_wr_data;
        end
    end

    // Advance the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (acc && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (field.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (acc && has_result)
        begin
            out_byte_valid_reg <= emit;
            out_byte_reg       <= emit ? text.data_byte : '0;
            out_done_reg       <= !emit;
            out_found_reg      <= done_present;
            out_len_reg        <= done_present ? len_ext[LEN_OUT_W-1:0] : '0;
            out_lines_reg      <= emit ? '0 : val_next;
        end
    end

    assign field.valid            = out_valid_reg;
    assign field.byte_valid       = out_byte_valid_reg;
    assign field.out_byte         = out_byte_reg;
    assign field.field_done       = out_done_reg;
    assign field.found            = out_found_reg;
    assign field.field_length     = out_len_reg;
    assign field.lines_with_value = out_lines_reg;

    // Checks
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(FIELD_LEN_MAX))
        else $error("field length counter passed its limit");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        acc && text.line_end |=> col_reg == '0 && !finished_reg && phase_reg == PH_START)
        else $error("line end did not restart the parser");

    a_value_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> val_reg >= $past(val_reg))
        else $error("line value count decreased");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_byte_valid_reg != out_done_reg)
        else $error("result word is neither a byte nor a done word");

    a_emit_sel: assert property (@(posedge clk) disable iff (!rst_n)
        acc && emit |=> out_valid_reg && out_byte_valid_reg && $past(sel))
        else $error("byte emitted outside the selected column");

endmodule

@@ tb/sv/csv_column_extractor_test.sv @@
// Testbench for the CSV column extractor: directed lines, then random CSV traffic.
// Predicts every field word from its own parser model and checks the field channel.
// Depends on cce_pkg, cce_if.sv and csv_column_extractor.sv.
module csv_column_extractor_test;
    import cce_pkg::*;

    localparam int          LEN_CAP         = 511;
    localparam logic [7:0]  COLUMN_LAST     = 8'd255;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          TAIL_CYCLES     = 10;
    localparam int          REPORT_LIMIT    = 10;

    typedef enum int {
        IDLE_NONE = 0,
        IDLE_SEND = 1,
        IDLE_RECV = 2,
        IDLE_BOTH = 3
    } idle_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } char_word_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        field_done;
        logic        found;
        logic [8:0]  field_length;
        logic [15:0] lines_with_value;
    } field_word_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    cce_char_if  text_bus ();
    cce_field_if field_bus ();

    csv_column_extractor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text        (text_bus),
        .field       (field_bus)
    );

    // Parser model state
    phase_t      parse_at;
    bit          line_closed;
    logic [7:0]  field_col;
    logic [8:0]  sel_len;
    logic [15:0] value_lines;
    logic [7:0]  target_col;
    field_word_t expected_words[$];

    // Stimulus and handshake bookkeeping
    char_word_t  pending_chars[$];
    int          words_queued    = 0;
    idle_mode_t  idle_mode       = IDLE_NONE;
    bit          offering        = 1'b0;
    bit          char_taken      = 1'b0;
    int          hold_off_asked  = 0;
    int          hold_off_served = 0;
    int          hold_off_left   = 0;
    int          cycle_count     = 0;
    int          bad_words       = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- parser model

    function automatic void emit_char(logic [7:0] ch);
        field_word_t w;
        w = '0;
        w.byte_valid = 1'b1;
        w.out_byte = ch;
        expected_words.push_back(w);
        if (sel_len < LEN_CAP)
            sel_len++;
    endfunction

    function automatic void emit_done(bit present);
        field_word_t w;
        if (present && sel_len != 0 && value_lines != 16'hFFFF)
            value_lines++;
        w = '0;
        w.field_done = 1'b1;
        w.found = present;
        w.field_length = present ? sel_len : 9'd0;
        w.lines_with_value = value_lines;
        expected_words.push_back(w);
        line_closed = 1'b1;
    endfunction

    // Close the current field: report it if selected, else advance the column
    function automatic void close_field();
        parse_at = PH_START;
        if (field_col == target_col)
            emit_done(1'b1);
        else if (field_col != COLUMN_LAST)
            field_col++;
    endfunction

    // Close the line content on line end or a zero byte
    function automatic void close_content();
        if (!line_closed)
        begin
            if (parse_at != PH_START)
                close_field();
            if (!line_closed)
                emit_done(1'b0);
        end
        line_closed = 1'b1;
    endfunction

    function automatic void parse_word(logic [7:0] ch, logic eol);
        bit hit;
        bit sep;
        hit = (field_col == target_col);
        sep = (ch == CH_SEMI) || (ch == CH_PIPE);
        if (eol)
        begin
            close_content();
            parse_at = PH_START;
            line_closed = 1'b0;
            field_col = '0;
            sel_len = '0;
        end
        else if (!line_closed)
        begin
            if (ch == CH_NUL)
                close_content();
            else
            begin
                case (parse_at)
                    PH_START:
                        if (ch == CH_QUOTE)
                            parse_at = PH_QUOTED;
                        else if (sep)
                            close_field();
                        else
                        begin
                            parse_at = PH_PLAIN;
                            if (hit)
                                emit_char(ch);
                        end
                    PH_PLAIN:
                        if (sep)
                            close_field();
                        else if (hit)
                            emit_char(ch);
                    PH_QUOTED:
                        if (ch == CH_QUOTE)
                            parse_at = PH_QSEEN;
                        else if (hit)
                            emit_char(ch);
                    default:
                        if (sep)
                            close_field();
                        else
                        begin
                            parse_at = PH_QUOTED;
                            if (hit)
                                emit_char(ch);
                        end
                endcase
            end
        end
    endfunction

    function automatic string word_text(field_word_t w);
        return $sformatf("byte_valid=%0b out_byte=%02h field_done=%0b found=%0b len=%0d lines=%0d",
                         w.byte_valid, w.out_byte, w.field_done, w.found,
                         w.field_length, w.lines_with_value);
    endfunction

    // ---------------------------------------------------------------- line builders

    function automatic void put_char(logic [7:0] ch);
        char_word_t w;
        w.data_byte = ch;
        w.line_end = 1'b0;
        pending_chars.push_back(w);
        words_queued++;
    endfunction

    function automatic void put_eol();
        char_word_t w;
        w.data_byte = 8'($urandom_range(0, 255));
        w.line_end = 1'b1;
        pending_chars.push_back(w);
        words_queued++;
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function automatic logic [7:0] pick_delim();
        return ($urandom_range(0, 1) != 0) ? CH_SEMI : CH_PIPE;
    endfunction

    // Nonzero character that is no delimiter; no quote when no_quote is set
    function automatic logic [7:0] plain_char(bit no_quote);
        logic [7:0] ch;
        do
        begin
            if ($urandom_range(0, 3) == 0)
                ch = 8'($urandom_range(1, 255));
            else
                ch = 8'h61 + 8'($urandom_range(0, 25));
        end
        while (ch == CH_SEMI || ch == CH_PIPE || (no_quote && ch == CH_QUOTE));
        return ch;
    endfunction

    function automatic void add_plain_field(int len);
        for (int i = 0; i < len; i++)
            put_char(plain_char(i == 0));
    endfunction

    function automatic void add_quoted_field(int len, bit closed);
        put_char(CH_QUOTE);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    put_char(CH_QUOTE);
                    put_char(CH_QUOTE);
                end
                1:
                begin
                    put_char(CH_QUOTE);
                    put_char(plain_char(1'b1));
                end
                2:       put_char(pick_delim());
                default: put_char(plain_char(1'b1));
            endcase
        end
        if (closed)
            put_char(CH_QUOTE);
    endfunction

    // Well-formed line; only the last field may be a quoted field cut by the line end
    function automatic void add_csv_line(int max_fields);
        int nf;
        nf = $urandom_range(0, max_fields);
        for (int f = 0; f < nf; f++)
        begin
            if (f != 0)
                put_char(pick_delim());
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_plain_field($urandom_range(1, 6));
                5, 6, 7:       add_quoted_field($urandom_range(0, 6), 1'b1);
                8:             ;  // leave the field empty
                default:       add_quoted_field($urandom_range(0, 6), f != nf - 1);
            endcase
        end
        if (nf != 0 && $urandom_range(0, 7) == 0)
            put_char(pick_delim());
        put_eol();
    endfunction

    function automatic void add_noise_line();
        int         len;
        logic [7:0] ch;
        len = $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 15))
                0:          ch = CH_NUL;
                1, 2, 3:    ch = CH_QUOTE;
                4, 5:       ch = pick_delim();
                default:    ch = 8'($urandom_range(0, 255));
            endcase
            put_char(ch);
        end
        put_eol();
    endfunction

    // Many short fields, to run the column index into saturation
    function automatic void add_wide_line(int nf);
        for (int f = 0; f < nf; f++)
        begin
            if (f != 0)
                put_char(pick_delim());
            if ($urandom_range(0, 2) != 0)
                put_char(plain_char(1'b1));
        end
        put_eol();
    endfunction

    function automatic void add_random_lines(int count, int max_fields);
        int start;
        start = words_queued;
        while (words_queued - start < count)
        begin
            if ($urandom_range(0, 4) == 0)
                add_noise_line();
            else
                add_csv_line(max_fields);
        end
    endfunction

    // ---------------------------------------------------------------- sequencing

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_chars.size() != 0 || offering || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_target(logic [7:0] col);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= col;
        target_col = col;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic bit sender_goes();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) >= 85;
            IDLE_BOTH: return $urandom_range(0, 99) >= 35;
            default:   return 1'b1;
        endcase
    endfunction

    function automatic bit receiver_takes();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) >= 85;
            IDLE_BOTH: return $urandom_range(0, 99) >= 35;
            default:   return 1'b1;
        endcase
    endfunction

    // Text driver: hold each word until taken, then advance
    always @(negedge clk)
    begin
        char_word_t w;
        if (offering && char_taken)
            offering = 1'b0;
        if (!offering && pending_chars.size() != 0 && sender_goes())
        begin
            w = pending_chars.pop_front();
            offering = 1'b1;
            text_bus.data_byte <= w.data_byte;
            text_bus.line_end <= w.line_end;
        end
        text_bus.valid <= offering;
    end

    // Field receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_off_served != hold_off_asked)
        begin
            hold_off_served = hold_off_asked;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            field_bus.ready <= 1'b0;
        end
        else
            field_bus.ready <= receiver_takes();
    end

    // Monitor: predict from taken text words, check taken field words
    always @(posedge clk)
    begin
        field_word_t got;
        field_word_t want;
        cycle_count++;
        char_taken = text_bus.valid && text_bus.ready;
        if (char_taken)
            parse_word(text_bus.data_byte, text_bus.line_end);
        if (field_bus.valid && field_bus.ready)
        begin
            got = {field_bus.byte_valid, field_bus.out_byte, field_bus.field_done,
                   field_bus.found, field_bus.field_length, field_bus.lines_with_value};
            if (expected_words.size() == 0)
            begin
                bad_words++;
                if (bad_words <= REPORT_LIMIT)
                    $display("unexpected field word: %s", word_text(got));
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte
                    || got.field_done !== want.field_done || got.found !== want.found
                    || got.field_length !== want.field_length
                    || got.lines_with_value !== want.lines_with_value)
                begin
                    bad_words++;
                    if (bad_words <= REPORT_LIMIT)
                    begin
                        $display("field word mismatch at cycle %0d", cycle_count);
                        $display("  expected %s", word_text(want));
                        $display("  actual   %s", word_text(got));
                    end
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Stimulus: reset, directed lines, then random phases
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        text_bus.valid = 1'b0;
        text_bus.data_byte = '0;
        text_bus.line_end = 1'b0;
        field_bus.ready = 1'b0;
        parse_at = PH_START;
        line_closed = 1'b0;
        field_col = '0;
        sel_len = '0;
        value_lines = '0;
        target_col = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines on the reset column
        put_eol();                          // empty line: column absent
        put_text("ab;c");                   // rest of line ignored after done
        put_eol();
        put_text(";x");                     // empty field, present with length 0
        put_eol();
        put_text("\"q\"\"x;\"|");           // doubled quote, delimiter inside quotes
        put_eol();
        put_text("k");                      // zero byte ends the content
        put_char(CH_NUL);
        put_text("z");
        put_eol();
        put_text("\"ab");                   // quoted field cut by line end
        put_eol();
        put_char(8'hFF);
        put_eol();
        wait_drained();

        // Change the column at a field boundary in mid-line
        set_target(8'd1);
        put_text("a;");
        wait_drained();
        set_target(8'd2);
        put_text("b;c");
        put_eol();
        put_text("x|y|");                   // field starting at line end: absent
        put_eol();
        wait_drained();

        idle_mode = IDLE_NONE;
        set_target(8'($urandom_range(0, 3)));
        add_random_lines(120, 6);
        wait_drained();

        idle_mode = IDLE_SEND;
        set_target(8'd0);
        add_random_lines(120, 4);
        wait_drained();

        // Long receiver hold-off while text keeps coming
        idle_mode = IDLE_RECV;
        set_target(8'($urandom_range(1, 5)));
        add_random_lines(120, 8);
        hold_off_asked++;
        wait_drained();

        // Last column: index saturation on a wide line
        idle_mode = IDLE_BOTH;
        set_target(COLUMN_LAST);
        add_wide_line(300);
        add_random_lines(80, 6);
        wait_drained();

        // Pause the text until every result is in, then a field past the length cap
        set_target(8'd0);
        add_random_lines(80, 4);
        wait_drained();
        add_plain_field(LEN_CAP + 20);
        put_eol();
        add_random_lines(80, 4);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            idle_mode = idle_mode_t'(p);
            set_target(8'($urandom_range(0, 7)));
            add_random_lines(60, 8);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (bad_words == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ csv_column_extractor.f @@
sv/cce_pkg.sv
sv/cce_if.sv
sv/csv_column_extractor.sv
tb/sv/csv_column_extractor_test.sv
